// ===== design/assert_macros.svh =====
// Assertion macros for the design files that include them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion with explicit clock and active-low reset
`define ASSERT_CLK(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Concurrent assertion on the usual clk_i / rst_ni pair
`define ASSERT_STD(name, prop, msg) \
  `ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

// ===== design/sgac_pkg.sv =====
// Types and constants for the steering and gear comparator block
`timescale 1ns / 1ps

package sgac_pkg;

  // Number of players served and width of a player index
  localparam int unsigned PLAYER_COUNT = 4;
  localparam int unsigned PLAYER_W     = 2;
  localparam int unsigned DIAL_W       = 8;
  localparam int unsigned GEAR_SW_W    = 4;
  localparam int unsigned GEAR_W       = 3;
  localparam int unsigned OFFSET_W     = 5;
  localparam int unsigned WDATA_W      = 8;
  localparam int unsigned THRESH_W     = 4;
  localparam int unsigned VALUE_W      = 5;
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned S_TDATA_W    = 32;
  localparam int unsigned M_TDATA_W    = 8;

  // Command codes carried in tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  // Gear switch patterns that select a gear
  localparam logic [GEAR_SW_W-1:0] SW_GEAR1 = 4'b0001;
  localparam logic [GEAR_SW_W-1:0] SW_GEAR2 = 4'b0010;
  localparam logic [GEAR_SW_W-1:0] SW_GEAR3 = 4'b0100;
  localparam logic [GEAR_SW_W-1:0] SW_GEAR4 = 4'b1000;

  // One input item as held in the input register
  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [PLAYER_W-1:0]  player;
    logic [DIAL_W-1:0]    dial_position;
    logic [GEAR_SW_W-1:0] gear_switches;
    logic [OFFSET_W-1:0]  address_offset;
    logic [WDATA_W-1:0]   write_data;
  } item_t;

endpackage

// ===== design/steering_gear_analog_comparator_top.sv =====
// Top level of the four-player steering and gear comparator block
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   Slave channel s_axis_*: one item per handshake; tuser carries the command
//   (sample, write threshold, read comparator), tdata the item fields.
//   Master channel m_axis_*: one item per read command; tdata bit 0 is
//   comparator_high. Sample and write items give no output item.
//   Items are taken into an input register, processed by short logic that
//   updates the per-player state, and a read result is stored in the output
//   register. Output valid rises as a read item leaves the input register.
//   Throughput is one item per cycle while no read waits on a stalled output;
//   the input register and the output register each hold one item.
//   While the receiver stalls with a result waiting, sample and write items
//   still pass and update state; a read item waits in the input register and
//   s_axis_tready_o drops only then.
//   Reset (rst_ni low, asynchronous) clears all dial positions, directions,
//   flags, gears and the threshold to zero and empties both registers.
module steering_gear_analog_comparator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [1:0] player, [9:2] dial_position, [13:10] gear_switches,
  // [18:14] address_offset, [26:19] write_data, [31:27] zero
  input  logic [sgac_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // [1:0] command
  input  logic [sgac_pkg::CMD_W-1:0]      s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [0] comparator_high, [7:1] zero
  output logic [sgac_pkg::M_TDATA_W-1:0]  m_axis_tdata_o
);

  // Input register
  logic            in_valid_q;
  sgac_pkg::item_t in_item_q;
  logic            in_adv;
  logic            in_is_read;

  // Per-player state and threshold
  logic [sgac_pkg::DIAL_W-1:0]   last_dial_q [sgac_pkg::PLAYER_COUNT];
  logic                          steer_dir_q [sgac_pkg::PLAYER_COUNT];
  logic                          phase_flag_q[sgac_pkg::PLAYER_COUNT];
  logic [sgac_pkg::GEAR_W-1:0]   gear_q      [sgac_pkg::PLAYER_COUNT];
  logic [sgac_pkg::THRESH_W-1:0] thresh_q;

  // Output register
  logic out_valid_q;
  logic out_cmp_q;
  logic out_cmp_d;

  // Sample decode
  logic                        sample_en;
  logic [sgac_pkg::DIAL_W-1:0] dial_diff;
  logic                        gear_hit;
  logic [sgac_pkg::GEAR_W-1:0] gear_new;

  // Read decode
  logic [sgac_pkg::PLAYER_W-1:0] rd_player;
  logic [sgac_pkg::VALUE_W-1:0]  rd_value;

  // Handshake: an item advances unless it is a read blocked by a full output
  assign in_is_read = (in_item_q.command == sgac_pkg::CMD_READ);
  assign in_adv     = in_valid_q && (!in_is_read || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // Unpack the item into the input register
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_item_q.command        <= s_axis_tuser_i;
      in_item_q.player         <= s_axis_tdata_i[1:0];
      in_item_q.dial_position  <= s_axis_tdata_i[9:2];
      in_item_q.gear_switches  <= s_axis_tdata_i[13:10];
      in_item_q.address_offset <= s_axis_tdata_i[18:14];
      in_item_q.write_data     <= s_axis_tdata_i[26:19];
    end
  end

  // Sample: wrapped dial difference and gear switch decode
  assign sample_en = in_adv && (in_item_q.command == sgac_pkg::CMD_SAMPLE) &&
                     ({1'b0, in_item_q.player} < (sgac_pkg::PLAYER_W+1)'(sgac_pkg::PLAYER_COUNT));
  assign dial_diff = in_item_q.dial_position - last_dial_q[in_item_q.player];

  always_comb begin
    gear_hit = 1'b1;
    gear_new = '0;
    case (in_item_q.gear_switches)
      sgac_pkg::SW_GEAR1: gear_new = sgac_pkg::GEAR_W'(1);
      sgac_pkg::SW_GEAR2: gear_new = sgac_pkg::GEAR_W'(2);
      sgac_pkg::SW_GEAR3: gear_new = sgac_pkg::GEAR_W'(3);
      sgac_pkg::SW_GEAR4: gear_new = sgac_pkg::GEAR_W'(4);
      default:            gear_hit = 1'b0;
    endcase
  end

  // Per-player state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sgac_pkg::PLAYER_COUNT; i++) begin
        last_dial_q[i]  <= '0;
        steer_dir_q[i]  <= 1'b0;
        phase_flag_q[i] <= 1'b0;
        gear_q[i]       <= '0;
      end
    end else if (sample_en) begin
      last_dial_q[in_item_q.player]  <= in_item_q.dial_position;
      phase_flag_q[in_item_q.player] <= last_dial_q[in_item_q.player][0];
      if (dial_diff != '0) begin
        steer_dir_q[in_item_q.player] <= ~dial_diff[sgac_pkg::DIAL_W-1];
      end
      if (gear_hit) begin
        gear_q[in_item_q.player] <= gear_new;
      end
    end
  end

  // Threshold write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= '0;
    end else if (in_adv && (in_item_q.command == sgac_pkg::CMD_WRITE)) begin
      thresh_q <= in_item_q.write_data[sgac_pkg::THRESH_W-1:0];
    end
  end

  // Read: select 4*gear or 8*(flag+direction), compare with threshold
  assign rd_player = in_item_q.address_offset[2:1];

  always_comb begin
    rd_value = '0;
    if ({1'b0, rd_player} < (sgac_pkg::PLAYER_W+1)'(sgac_pkg::PLAYER_COUNT)) begin
      if (in_item_q.address_offset[0]) begin
        rd_value = {gear_q[rd_player], 2'b00};
      end else begin
        rd_value = {(sgac_pkg::VALUE_W-3)'({1'b0, phase_flag_q[rd_player]} +
                                            {1'b0, steer_dir_q[rd_player]}), 3'b000};
      end
    end
    out_cmp_d = (rd_value > {1'b0, thresh_q});
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_adv && in_is_read) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_is_read) begin
      out_cmp_q <= out_cmp_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(sgac_pkg::M_TDATA_W-1)'(0), out_cmp_q};

  // Assertions
  `ASSERT_STD(a_read_blocked_when_stalled,
              (in_valid_q && in_is_read && out_valid_q && !m_axis_tready_i) |-> !in_adv,
              "read advanced into a stalled output register")
  `ASSERT_STD(a_out_only_from_read,
              (!out_valid_q && !(in_adv && in_is_read)) |=> !out_valid_q,
              "output item appeared without a read")
  `ASSERT_STD(a_thresh_only_on_write,
              !$stable(thresh_q) |-> $past(in_adv && (in_item_q.command == sgac_pkg::CMD_WRITE)),
              "threshold changed without a write")

  for (genvar g = 0; g < sgac_pkg::PLAYER_COUNT; g++) begin : g_gear_chk
    `ASSERT_STD(a_gear_range,
                gear_q[g] <= sgac_pkg::GEAR_W'(4),
                "selected gear out of range")
  end

endmodule
